// ----- rtl/psh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the producer supply hold machine.
// No dependencies; psh_calc and the top level refer to it by scoped names.
package psh_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int TIME_BITS_DEF = 48;

  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 10;
  localparam int LAYER_W = 2;
  localparam int NOW_W   = 48;
  localparam int STATE_W = 3;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd2;

  // spatial layer at or above which a producer counts as fully supplied
  localparam logic [LAYER_W-1:0] LAYER_FULL = 2'd2;

  typedef enum logic [STATE_W-1:0] {
    SUP_ACTIVE = 3'd0,
    SUP_LOW    = 3'd1,
    SUP_HOLD   = 3'd2,
    SUP_PAUSED = 3'd3,
    SUP_WARMUP = 3'd4
  } supply_t;

  typedef enum logic [1:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_READ,
    PH_CALC
  } phase_t;

  // controls from the sequencer to the update datapath
  typedef struct packed {
    logic sums_en;
    logic had;
  } psh_ctl_t;

endpackage

// ----- rtl/psh_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/psh_calc.sv -----
`timescale 1ns / 1ps
// Entry update datapath: saturating timer sums in a first stage, then state,
// timer and keep decisions. Depends on psh_pkg.
module psh_calc #(
  parameter int TIME_BITS = psh_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  psh_pkg::psh_ctl_t             ctl,
  input  logic                          seen,
  input  logic                          zero,
  input  logic [psh_pkg::LAYER_W-1:0]   layer,
  input  logic [TIME_BITS-1:0]          now,
  input  psh_pkg::supply_t              prev_raw,
  input  logic [TIME_BITS-1:0]          zs_raw,
  input  logic [TIME_BITS:0]            pe_raw,
  input  logic [TIME_BITS:0]            re_raw,
  input  logic [psh_pkg::CFG_W-1:0]     hold_cfg,
  input  logic [psh_pkg::CFG_W-1:0]     pause_cfg,
  input  logic [psh_pkg::CFG_W-1:0]     warm_cfg,
  output psh_pkg::supply_t              st,
  output logic [TIME_BITS-1:0]          hold,
  output logic                          kept_c,
  output logic [TIME_BITS-1:0]          zs_out,
  output logic [TIME_BITS:0]            pe_out,
  output logic [TIME_BITS:0]            re_out
);

  localparam int SW = ((TIME_BITS > psh_pkg::CFG_W) ? TIME_BITS : psh_pkg::CFG_W) + 1;
  localparam logic [SW-1:0] TMAX_W = (SW'(1) << TIME_BITS) - SW'(1);

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [psh_pkg::CFG_W-1:0] d);
    logic [SW-1:0] s;
    s = SW'(t) + SW'(d);
    sat_add = (s > TMAX_W) ? '1 : s[TIME_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0] zs_base, zs_eff;

  logic                 had_q;
  psh_pkg::supply_t     prev_q;
  logic [TIME_BITS-1:0] zs_q;
  logic [TIME_BITS:0]   pe_q, re_q;
  logic [TIME_BITS-1:0] hold_sum_q, pause_sum_q, resume_sum_q;

  logic [TIME_BITS:0]   re_mid;
  logic                 pause_due, resume_due;
  psh_pkg::supply_t     level;

  // stage one: pick the zero-demand start time and form the deadlines
  assign zs_base = ctl.had ? zs_raw : '0;
  assign zs_eff  = !zero ? '0 : ((zs_base == '0) ? now : zs_base);

  always_ff @(posedge clk) begin
    if (ctl.sums_en) begin
      had_q        <= ctl.had;
      prev_q       <= ctl.had ? prev_raw : psh_pkg::SUP_ACTIVE;
      zs_q         <= zs_eff;
      pe_q         <= ctl.had ? pe_raw : '0;
      re_q         <= ctl.had ? re_raw : '0;
      hold_sum_q   <= sat_add(zs_eff, hold_cfg);
      pause_sum_q  <= sat_add(zs_eff, pause_cfg);
      resume_sum_q <= sat_add(now, warm_cfg);
    end
  end

  // stage two: arm timers, step the state, decide whether the entry stays
  assign hold   = zero ? hold_sum_q : '0;
  assign pe_out = !zero ? '0 : (pe_q[TIME_BITS] ? pe_q : {1'b1, pause_sum_q});
  assign re_mid = (!zero && had_q && (prev_q == psh_pkg::SUP_PAUSED) && !re_q[TIME_BITS]) ?
                  {1'b1, resume_sum_q} : re_q;

  assign pause_due  = pe_out[TIME_BITS] && (now >= pe_out[TIME_BITS-1:0]);
  assign resume_due = re_mid[TIME_BITS] && (now >= re_mid[TIME_BITS-1:0]);
  assign level      = (layer < psh_pkg::LAYER_FULL) ? psh_pkg::SUP_LOW : psh_pkg::SUP_ACTIVE;

  always_comb begin
    st = psh_pkg::SUP_HOLD;
    if (!zero) begin
      case (prev_q)
        psh_pkg::SUP_PAUSED: st = psh_pkg::SUP_WARMUP;
        psh_pkg::SUP_WARMUP: st = resume_due ? level : psh_pkg::SUP_WARMUP;
        default:             st = level;
      endcase
    end else begin
      case (prev_q)
        psh_pkg::SUP_HOLD:   st = pause_due ? psh_pkg::SUP_PAUSED : psh_pkg::SUP_HOLD;
        psh_pkg::SUP_PAUSED: st = psh_pkg::SUP_PAUSED;
        default:             st = psh_pkg::SUP_HOLD;
      endcase
    end
  end

  // drop the warmup timer whenever a seen producer is not in warmup
  assign re_out = (seen && (st != psh_pkg::SUP_WARMUP)) ? '0 : re_mid;
  assign kept_c = seen || (hold > now) || (st == psh_pkg::SUP_PAUSED);
  assign zs_out = zs_q;

endmodule

// ----- rtl/producer_supply_hold_machine.sv -----
`timescale 1ns / 1ps
// Top level of the producer supply hold machine: sequencer, entry table,
// config registers and result register. Depends on psh_pkg, psh_ram, psh_calc.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one producer's demand word per
//   round: slot, seen flag, visible count, top spatial layer and time.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   supply state, hold deadline and keep flag, in input order.
//   Config channel (cfg_valid/cfg_ready) is always ready; index 0 hold time,
//   1 pause confirm, 2 resume warmup. Write it only while the block is idle.
//   Each word passes through table read, deadline sums, state update with
//   write-back. The single table port and the read-modify-write of one entry
//   mean a new word is accepted only after the last one is written back, and
//   the result becomes valid once the update phase loads the result register.
//   The result register parts the sides: a new word is accepted while a
//   result waits; the update stage stalls only if the result is still held.
//   Reset clears the table's valid bits with a pass over all PRODUCER_SLOTS
//   entries, one entry per cycle, during which in_ready stays low.
module producer_supply_hold_machine #(
  parameter int PRODUCER_SLOTS = psh_pkg::SLOTS_DEF,
  parameter int TIME_BITS      = psh_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [psh_pkg::SLOT_W-1:0]      producer_slot,
  input  logic                            seen,
  input  logic [psh_pkg::COUNT_W-1:0]     visible_count,
  input  logic [psh_pkg::LAYER_W-1:0]     top_spatial_layer,
  input  logic [psh_pkg::NOW_W-1:0]       now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psh_pkg::STATE_W-1:0]     supply_state,
  output logic [psh_pkg::NOW_W-1:0]       hold_until_ms,
  output logic                            kept,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psh_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = (PRODUCER_SLOTS > 1) ? $clog2(PRODUCER_SLOTS) : 1;
  localparam int T  = TIME_BITS;
  localparam int EW = 3 * T + 6;
  // entry layout: valid | state | zero_since | pause timer | resume timer
  localparam int V_BIT  = 3 * T + 5;
  localparam int ST_LSB = 3 * T + 2;
  localparam int ZS_LSB = 2 * T + 2;
  localparam int PE_LSB = T + 1;

  psh_pkg::phase_t   phase, phase_next;
  psh_pkg::psh_ctl_t ctl;

  logic [psh_pkg::CFG_W-1:0] hold_cfg, pause_cfg, warm_cfg;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] slot_addr;
  logic          oor, seen_q, zero_q, skip;
  logic [psh_pkg::LAYER_W-1:0] layer_q;
  logic [T-1:0]  now_q;

  logic          in_acc, out_load, ram_we, had;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata, entry_new;

  psh_pkg::supply_t st;
  logic [T-1:0]     hold, zs_new;
  logic [T:0]       pe_new, re_new;
  logic             calc_kept;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign had       = ram_rdata[V_BIT] && !oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cfg  <= '0;
      pause_cfg <= '0;
      warm_cfg  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psh_pkg::CFG_HOLD:   hold_cfg  <= cfg_data;
        psh_pkg::CFG_PAUSE:  pause_cfg <= cfg_data;
        psh_pkg::CFG_WARMUP: warm_cfg  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= psh_pkg::PH_CLEAR;
      clr_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (phase == psh_pkg::PH_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    ctl        = '0;
    ctl.had    = had;
    case (phase)
      psh_pkg::PH_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == AW'(PRODUCER_SLOTS - 1)) begin
          phase_next = psh_pkg::PH_IDLE;
        end
      end
      psh_pkg::PH_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          phase_next = psh_pkg::PH_READ;
        end
      end
      psh_pkg::PH_READ: begin
        ctl.sums_en = 1'b1;
        phase_next  = psh_pkg::PH_CALC;
      end
      psh_pkg::PH_CALC: begin
        // hold the update until the result register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          ram_we     = !skip;
          phase_next = psh_pkg::PH_IDLE;
        end
      end
      default: phase_next = psh_pkg::PH_IDLE;
    endcase
  end

  // latch the word; it stays put until the update is done
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_addr <= AW'(producer_slot);
      oor       <= 32'(producer_slot) >= 32'(PRODUCER_SLOTS);
      seen_q    <= seen;
      zero_q    <= !seen || (visible_count == '0);
      layer_q   <= top_spatial_layer;
      now_q     <= T'(now_ms);
    end
    if (phase == psh_pkg::PH_READ) begin
      // unknown slot that is not seen, or slot out of range: answer zeros
      skip <= oor || (!seen_q && !had);
    end
  end

  assign entry_new = {calc_kept, st, zs_new, pe_new, re_new};
  assign ram_waddr = (phase == psh_pkg::PH_CLEAR) ? clr_cnt : slot_addr;
  assign ram_wdata = (phase == psh_pkg::PH_CLEAR) ? '0 : entry_new;

  psh_ram #(
    .WIDTH (EW),
    .DEPTH (PRODUCER_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (AW'(producer_slot)),
    .rdata (ram_rdata)
  );

  psh_calc #(
    .TIME_BITS (TIME_BITS)
  ) u_calc (
    .clk       (clk),
    .ctl       (ctl),
    .seen      (seen_q),
    .zero      (zero_q),
    .layer     (layer_q),
    .now       (now_q),
    .prev_raw  (psh_pkg::supply_t'(ram_rdata[ST_LSB +: psh_pkg::STATE_W])),
    .zs_raw    (ram_rdata[ZS_LSB +: T]),
    .pe_raw    (ram_rdata[PE_LSB +: T + 1]),
    .re_raw    (ram_rdata[T:0]),
    .hold_cfg  (hold_cfg),
    .pause_cfg (pause_cfg),
    .warm_cfg  (warm_cfg),
    .st        (st),
    .hold      (hold),
    .kept_c    (calc_kept),
    .zs_out    (zs_new),
    .pe_out    (pe_new),
    .re_out    (re_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      supply_state  <= skip ? psh_pkg::SUP_ACTIVE : st;
      hold_until_ms <= skip ? '0 : psh_pkg::NOW_W'(hold);
      kept          <= !skip && calc_kept;
    end
  end

`ifndef ASSERT_OFF
  a_seq_order: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (phase == psh_pkg::PH_READ) ##1 (phase == psh_pkg::PH_CALC))
    else $error("update did not follow the accepted word");

  a_paused_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kept) |-> (supply_state != psh_pkg::SUP_PAUSED))
    else $error("paused producer reported as dropped");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((phase == psh_pkg::PH_CLEAR) || (phase == psh_pkg::PH_CALC)))
    else $error("table written outside clear or update");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ((phase == psh_pkg::PH_CALC) && out_valid && !out_ready) |=>
      (phase == psh_pkg::PH_CALC))
    else $error("update left while result register was full");
`endif

endmodule
